FILE: rtl/sac_pkg.sv
// Shared constants for the set-associative LRU tag simulator.
// No dependencies; used by sac_lru_update and the core module.
package sac_pkg;

    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_MAX_SET_BITS = 10;
    localparam int DEF_ADDR_WIDTH   = 32;

    // stored tag width and the width of way counts (counts up to 31)
    localparam int TAG_W  = 32;
    localparam int WCNT_W = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_LINE_BITS = 4'd6;
    localparam logic [CFG_DATA_W-1:0] RST_SET_BITS  = 4'd6;
    localparam logic [CFG_DATA_W-1:0] RST_WAYS      = 4'd2;

endpackage

FILE: rtl/sac_tag_ram.sv
// Tag memory: one row per set, all ways of the set side by side.
// One write port, one read port, registered read data. Depends on nothing.
module sac_tag_ram #(
    parameter int ADDR_W = 10,
    parameter int ROW_W  = 256
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [2**ADDR_W];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sac_lru_update.sv
// LRU lookup and reorder of one set row: hit search, move-to-front, install.
// Uses sac_pkg for the tag and way-count widths.
module sac_lru_update #(
    parameter int MAX_WAYS = sac_pkg::DEF_MAX_WAYS
) (
    input  logic [MAX_WAYS*sac_pkg::TAG_W-1:0] row_in,
    input  logic [sac_pkg::TAG_W-1:0]          tag,
    input  logic [sac_pkg::WCNT_W-1:0]         nways,
    output logic [MAX_WAYS*sac_pkg::TAG_W-1:0] row_out,
    output logic                               miss
);

    logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0] old_w;
    logic [MAX_WAYS-1:0][sac_pkg::TAG_W-1:0] new_w;
    logic [MAX_WAYS-1:0]                     match;
    logic [sac_pkg::WCNT_W-1:0]              pos;

    assign old_w = row_in;

    always_comb begin
        for (int k = 0; k < MAX_WAYS; k++) begin
            match[k] = (sac_pkg::WCNT_W'(k) < nways) && (old_w[k] == tag);
        end
    end

    // first matching way, else the last way in use drops out
    always_comb begin
        pos = nways - 1'b1;
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (match[k]) begin
                pos = sac_pkg::WCNT_W'(k);
            end
        end
    end

    always_comb begin
        new_w[0] = tag;
        for (int k = 1; k < MAX_WAYS; k++) begin
            if (sac_pkg::WCNT_W'(k) <= pos) begin
                new_w[k] = old_w[k-1];
            end else begin
                new_w[k] = old_w[k];
            end
        end
    end

    assign row_out = new_w;
    assign miss    = ~|match;

endmodule

FILE: rtl/set_assoc_lru_cache_tag_sim_core.sv
// Per reference: CALC, CHK, then UPD1 (one line) or UPD1, RD2, UPD2 (two lines), then DONE,
// which waits for the output to be free; a span error goes from CHK straight to DONE.
// One reference at a time; each line is a read-modify-write of one set row through the
// tag memory's read and write ports. Reset: synchronous, active low; then a clearing pass
// zeroes all tag rows (1024 by default) with s_tready low. Config writes always taken.
// Depends on sac_pkg, sac_tag_ram, sac_lru_update.
module set_assoc_lru_cache_tag_sim_core #(
    parameter int MAX_WAYS     = sac_pkg::DEF_MAX_WAYS,
    parameter int MAX_SET_BITS = sac_pkg::DEF_MAX_SET_BITS,
    parameter int ADDR_WIDTH   = sac_pkg::DEF_ADDR_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // address[31:0], access_bytes[39:32]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // miss[0], span_error[1], zero pad
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROW_W  = MAX_WAYS * sac_pkg::TAG_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_UPD1  = 3'd4;
    localparam logic [2:0] ST_RD2   = 3'd5;
    localparam logic [2:0] ST_UPD2  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [SET_AW-1:0]              clr_cnt_reg;
    logic [sac_pkg::CFG_DATA_W-1:0] line_bits_reg, set_bits_reg, ways_reg;

    logic [ADDR_WIDTH-1:0]          addr_reg;
    logic [7:0]                     size_reg;
    logic [ADDR_WIDTH-1:0]          l1_reg, l2_reg;
    logic [sac_pkg::TAG_W-1:0]      tag1_reg, tag2_reg;
    logic [SET_AW-1:0]              set1_reg, set2_reg;
    logic                           two_reg, err_reg, miss_reg;
    logic                           m_tvalid_reg, m_miss_reg, m_err_reg;

    logic [4:0]                     sb_eff;
    logic [sac_pkg::WCNT_W-1:0]     nw_eff;
    logic [SET_AW-1:0]              smask;
    logic [ADDR_WIDTH-1:0]          lmask, end_addr, l1_inc;
    logic [7:0]                     size_eff;
    logic [SET_AW-1:0]              set1_c, set2_c;
    logic                           same_c, adj_c;

    logic                           ram_we, ram_re;
    logic [SET_AW-1:0]              ram_waddr, ram_raddr;
    logic [ROW_W-1:0]               ram_wdata, ram_rdata, row_new;
    logic [sac_pkg::TAG_W-1:0]      upd_tag;
    logic                           upd_miss;
    logic                           out_free;

    // effective configuration
    assign sb_eff = ({1'b0, set_bits_reg} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                               : {1'b0, set_bits_reg};
    always_comb begin
        if (ways_reg == '0) begin
            nw_eff = sac_pkg::WCNT_W'(1);
        end else if ({1'b0, ways_reg} > sac_pkg::WCNT_W'(MAX_WAYS)) begin
            nw_eff = sac_pkg::WCNT_W'(MAX_WAYS);
        end else begin
            nw_eff = {1'b0, ways_reg};
        end
    end
    assign smask = ~({SET_AW{1'b1}} << sb_eff);
    assign lmask = {ADDR_WIDTH{1'b1}} >> line_bits_reg;

    // line arithmetic
    assign size_eff = (size_reg == 8'd0) ? 8'd1 : size_reg;
    assign end_addr = addr_reg + ADDR_WIDTH'(size_eff) - 1'b1;
    assign l1_inc   = (l1_reg + 1'b1) & lmask;
    assign same_c   = (l1_reg == l2_reg);
    assign adj_c    = (l1_inc == l2_reg);
    assign set1_c   = SET_AW'(l1_reg) & smask;
    assign set2_c   = SET_AW'(l2_reg) & smask;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == {SET_AW{1'b1}}) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_CALC;
            ST_CALC:  state_next = ST_CHK;
            ST_CHK:   state_next = (!same_c && !adj_c) ? ST_DONE : ST_UPD1;
            ST_UPD1:  state_next = two_reg ? ST_RD2 : ST_DONE;
            ST_RD2:   state_next = ST_UPD2;
            ST_UPD2:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = set1_reg;
        ram_wdata = row_new;
        ram_re    = 1'b0;
        ram_raddr = set1_c;
        upd_tag   = tag1_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_CHK:  ram_re = same_c || adj_c;
            ST_UPD1: ram_we = 1'b1;
            ST_RD2: begin
                ram_re    = 1'b1;
                ram_raddr = set2_reg;
            end
            ST_UPD2: begin
                ram_we    = 1'b1;
                ram_waddr = set2_reg;
                upd_tag   = tag2_reg;
            end
            default: ;
        endcase
    end

    sac_tag_ram #(
        .ADDR_W (SET_AW),
        .ROW_W  (ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sac_lru_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lru (
        .row_in  (ram_rdata),
        .tag     (upd_tag),
        .nways   (nw_eff),
        .row_out (row_new),
        .miss    (upd_miss)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            line_bits_reg <= sac_pkg::RST_LINE_BITS;
            set_bits_reg  <= sac_pkg::RST_SET_BITS;
            ways_reg      <= sac_pkg::RST_WAYS;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid) begin
                unique case (cfg_addr)
                    sac_pkg::REG_LINE_BITS: line_bits_reg <= cfg_data;
                    sac_pkg::REG_SET_BITS:  set_bits_reg  <= cfg_data;
                    sac_pkg::REG_WAYS:      ways_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            addr_reg <= ADDR_WIDTH'(s_tdata[31:0]);
            size_reg <= s_tdata[39:32];
        end
        if (state_reg == ST_CALC) begin
            l1_reg <= addr_reg >> line_bits_reg;
            l2_reg <= end_addr >> line_bits_reg;
        end
        if (state_reg == ST_CHK) begin
            tag1_reg <= sac_pkg::TAG_W'(l1_reg >> sb_eff);
            tag2_reg <= sac_pkg::TAG_W'(l2_reg >> sb_eff);
            set1_reg <= set1_c;
            set2_reg <= set2_c;
            two_reg  <= !same_c;
            err_reg  <= !same_c && !adj_c;
            miss_reg <= 1'b0;
        end
        if (state_reg == ST_UPD1 || state_reg == ST_UPD2) begin
            miss_reg <= miss_reg | upd_miss;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_miss_reg <= miss_reg && !err_reg;
            m_err_reg  <= err_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, m_err_reg, m_miss_reg};
    assign cfg_ready = 1'b1;

    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_tvalid_reg)
        else $error("result presented during memory clear");

    a_err_no_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("span error reported together with miss");

    a_no_rw_same_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("tag row read and written in the same cycle");

    a_second_line_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD2) |-> (two_reg && !err_reg && $past(state_reg) == ST_RD2))
        else $error("second line update without a valid two-line reference");

endmodule
